>>> hw/rtl/bsc_pkg.sv
package bsc_pkg;

    // Operand slice width of the wide multipliers.
    localparam int MUL_CHUNK_W = 32;

    localparam int CFG_INDEX_W = 2;
    localparam int CFG_DATA_W  = 64;
    localparam int CALIB_HIGH_W = 40;

    localparam logic [CFG_INDEX_W-1:0] CFG_CALIB_LOW  = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_CALIB_MID  = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_CALIB_HIGH = 2'd2;

    typedef struct packed {
        logic [23:0] raw_pressure;
        logic [23:0] raw_temperature;
    } in_item_t;

    typedef struct packed {
        logic signed [23:0] temperature_q16;
        logic [24:0]        pressure_q8;
    } out_item_t;

endpackage

>>> hw/rtl/bsc_wmul.sv
module bsc_wmul #(
    parameter int AW = 64,
    parameter int BW = 32,
    parameter int CW = bsc_pkg::MUL_CHUNK_W
) (
    input  logic                     clk,
    input  logic signed [AW-1:0]     a,
    input  logic signed [BW-1:0]     b,
    output logic signed [AW+BW-1:0]  p
);

    localparam int NC  = (AW + CW - 1) / CW;
    localparam int AXW = NC * CW;
    localparam int PW  = CW + 1 + BW;
    localparam int OW  = AW + BW;

    logic signed [AXW-1:0] a_ext;
    logic signed [PW-1:0]  part_next [NC];
    logic signed [PW-1:0]  part_reg  [NC];
    logic signed [OW-1:0]  p_next;
    logic signed [OW-1:0]  p_reg;

    assign a_ext = AXW'(a);

    // The lower slices are unsigned, only the top slice carries the sign.
    always_comb
    begin
        logic signed [CW:0] chunk;
        for (int i = 0; i < NC; i++)
        begin
            if (i == NC - 1)
                chunk = $signed({a_ext[AXW-1], a_ext[i*CW +: CW]});
            else
                chunk = $signed({1'b0, a_ext[i*CW +: CW]});
            part_next[i] = PW'(chunk) * PW'(b);
        end
    end

    always_comb
    begin
        p_next = '0;
        for (int i = 0; i < NC; i++)
        begin
            p_next = p_next + (OW'(part_reg[i]) <<< (i * CW));
        end
    end

    always_ff @(posedge clk)
    begin
        part_reg <= part_next;
        p_reg    <= p_next;
    end

    assign p = p_reg;

endmodule

>>> hw/rtl/barometric_sensor_compensation_core.sv
// Barometric sensor compensation core.
// Calibration is loaded through the write port (cfg_we, cfg_index, cfg_data):
// index 0 takes calibration bytes 0 to 7, index 1 bytes 8 to 15 and index 2
// bytes 16 to 20 (bits 39:0). Other indexes are ignored. Writes take effect
// at once and must only be made while no transaction is in flight.
// A sample transaction is accepted on every rising edge with start high and
// busy low; busy is never raised, so one sample may be given every cycle.
// Each sample yields one result, shown on result for a single cycle with done
// high, as it leaves the last pipeline stage. Results leave
// in the order the samples arrived. The throughput of one sample per clock
// is set by the twelve-stage pipeline: a temperature quadratic, then the
// pressure polynomial evaluated by Horner's rule in temperature with three
// multiply stages, the two widest of which split the operand into slices.
// The receiver cannot hold results off, so the pipeline never stalls.
// Reset clears the calibration registers and all in-flight transactions.
module barometric_sensor_compensation_core #(
    parameter int ChunkW = bsc_pkg::MUL_CHUNK_W
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               start,
    output logic                               busy,
    input  bsc_pkg::in_item_t                  sample,
    output logic                               done,
    output bsc_pkg::out_item_t                 result,
    input  logic                               cfg_we,
    input  logic [bsc_pkg::CFG_INDEX_W-1:0]    cfg_index,
    input  logic [bsc_pkg::CFG_DATA_W-1:0]     cfg_data
);

    localparam int NSTG = 12;

    logic [63:0] calib_low_reg;
    logic [63:0] calib_mid_reg;
    logic [bsc_pkg::CALIB_HIGH_W-1:0] calib_high_reg;
    logic [167:0] calib;

    logic [15:0]        coef_t1, coef_t2, coef_p5, coef_p6;
    logic signed [7:0]  coef_t3, coef_p3, coef_p4, coef_p7, coef_p8, coef_p10, coef_p11;
    logic signed [16:0] coef_p1m, coef_p2m;
    logic signed [15:0] coef_p9;

    logic [NSTG:1] valid_reg;

    // Stage 1
    logic signed [24:0] d_reg, d_next;
    logic signed [24:0] u_reg;
    // Stage 2
    logic signed [41:0] dt2_reg, up1_reg, up2_reg;
    logic signed [49:0] dd_reg, u2_reg;
    logic signed [32:0] up11_reg, up3_reg, up4_reg;
    // Stage 3
    logic signed [41:0] dt2_s3_reg, up1_s3_reg, up2_s3_reg;
    logic signed [57:0] ddt3_reg;
    logic signed [53:0] c2_s3_reg, c2_next;
    logic signed [32:0] c3_s3_reg, c3_next;
    logic signed [65:0] u2p9_reg;
    logic signed [57:0] u2p10_reg;
    // Stage 4
    logic signed [60:0] tl48, tl_rnd;
    logic signed [28:0] t_reg [4:9];
    logic signed [81:0] c1_reg [4:8];
    logic signed [81:0] c1_next;
    logic signed [53:0] c2_s4_reg, c2_s5_reg;
    logic signed [32:0] c3_s4_reg;
    logic signed [65:0] u2p9_s4_reg;
    logic signed [41:0] up1_s4_reg;
    logic signed [82:0] u3p11;
    // Stage 5
    logic signed [106:0] c0_reg [5:11];
    logic signed [106:0] c0_next;
    logic signed [61:0]  h3_reg;
    logic signed [23:0]  tsat_reg [5:11];
    logic signed [23:0]  tsat_next;
    // Stage 6
    logic signed [60:0]  g2_reg;
    // Stage 8
    logic signed [89:0]  h2;
    // Stage 9
    logic signed [87:0]  g1_reg;
    // Stage 11
    logic signed [116:0] h1;
    // Stage 12
    logic signed [117:0] acc;
    bsc_pkg::out_item_t  result_reg, result_next;

    assign calib = {calib_high_reg, calib_mid_reg, calib_low_reg};

    assign coef_t1  = calib[15:0];
    assign coef_t2  = calib[31:16];
    assign coef_t3  = $signed(calib[39:32]);
    assign coef_p1m = $signed({calib[55], calib[55:40]}) - 17'sd16384;
    assign coef_p2m = $signed({calib[71], calib[71:56]}) - 17'sd16384;
    assign coef_p3  = $signed(calib[79:72]);
    assign coef_p4  = $signed(calib[87:80]);
    assign coef_p5  = calib[103:88];
    assign coef_p6  = calib[119:104];
    assign coef_p7  = $signed(calib[127:120]);
    assign coef_p8  = $signed(calib[135:128]);
    assign coef_p9  = $signed(calib[151:136]);
    assign coef_p10 = $signed(calib[159:152]);
    assign coef_p11 = $signed(calib[167:160]);

    assign busy = 1'b0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            calib_low_reg  <= '0;
            calib_mid_reg  <= '0;
            calib_high_reg <= '0;
            valid_reg      <= '0;
        end
        else
        begin
            valid_reg <= {valid_reg[NSTG-1:1], start & ~busy};
            if (cfg_we)
            begin
                unique case (cfg_index)
                    bsc_pkg::CFG_CALIB_LOW:  calib_low_reg  <= cfg_data;
                    bsc_pkg::CFG_CALIB_MID:  calib_mid_reg  <= cfg_data;
                    bsc_pkg::CFG_CALIB_HIGH:
                        calib_high_reg <= cfg_data[bsc_pkg::CALIB_HIGH_W-1:0];
                    default: ;
                endcase
            end
        end
    end

    assign d_next = $signed({1'b0, sample.raw_temperature}) - $signed({1'b0, coef_t1, 8'h00});

    assign c2_next = (54'(coef_p7) <<< 45) + (54'(up3_reg) <<< 21);
    assign c3_next = (33'(coef_p8) <<< 22) + up4_reg;

    // Temperature in units of 2^-48, rounded half up to units of 2^-16.
    assign tl48   = (61'(dt2_s3_reg) <<< 18) + 61'(ddt3_reg);
    assign tl_rnd = tl48 + (61'sd1 <<< 31);

    assign c1_next = (82'($signed({1'b0, coef_p6})) <<< 63) + (82'(up2_s3_reg) <<< 40)
                   + (82'(u2p10_reg) <<< 21);

    assign c0_next = (107'($signed({1'b0, coef_p5})) <<< 88) + (107'(up1_s4_reg) <<< 65)
                   + (107'(u2p9_s4_reg) <<< 37) + (107'(u3p11) <<< 20);

    assign tsat_next = (t_reg[4][28:23] == {6{t_reg[4][28]}}) ? t_reg[4][23:0]
                     : (t_reg[4][28] ? 24'sh800000 : 24'sh7FFFFF);

    bsc_wmul #(.AW(50), .BW(33), .CW(ChunkW)) u_mul_u3 (
        .clk (clk),
        .a   (u2_reg),
        .b   (up11_reg),
        .p   (u3p11)
    );

    bsc_wmul #(.AW(61), .BW(29), .CW(ChunkW)) u_mul_h2 (
        .clk (clk),
        .a   (g2_reg),
        .b   (t_reg[6]),
        .p   (h2)
    );

    bsc_wmul #(.AW(88), .BW(29), .CW(ChunkW)) u_mul_h1 (
        .clk (clk),
        .a   (g1_reg),
        .b   (t_reg[9]),
        .p   (h1)
    );

    // Pressure in units of 2^-85, with half an output step added for rounding.
    assign acc = 118'(h1) + 118'(c0_reg[11]) + (118'sd1 <<< 76);

    always_comb
    begin
        result_next.temperature_q16 = tsat_reg[11];
        if (acc[117])
            result_next.pressure_q8 = '0;
        else if (|acc[116:102])
            result_next.pressure_q8 = '1;
        else
            result_next.pressure_q8 = acc[101:77];
    end

    always_ff @(posedge clk)
    begin
        // Stage 1
        d_reg <= d_next;
        u_reg <= $signed({1'b0, sample.raw_pressure});
        // Stage 2
        dt2_reg  <= 42'(d_reg) * 42'($signed({1'b0, coef_t2}));
        dd_reg   <= 50'(d_reg) * 50'(d_reg);
        u2_reg   <= 50'(u_reg) * 50'(u_reg);
        up11_reg <= 33'(u_reg) * 33'(coef_p11);
        up1_reg  <= 42'(u_reg) * 42'(coef_p1m);
        up2_reg  <= 42'(u_reg) * 42'(coef_p2m);
        up3_reg  <= 33'(u_reg) * 33'(coef_p3);
        up4_reg  <= 33'(u_reg) * 33'(coef_p4);
        // Stage 3
        ddt3_reg   <= 58'(dd_reg) * 58'(coef_t3);
        dt2_s3_reg <= dt2_reg;
        up1_s3_reg <= up1_reg;
        up2_s3_reg <= up2_reg;
        c2_s3_reg  <= c2_next;
        c3_s3_reg  <= c3_next;
        u2p9_reg   <= 66'(u2_reg) * 66'(coef_p9);
        u2p10_reg  <= 58'(u2_reg) * 58'(coef_p10);
        // Stage 4
        t_reg[4]    <= tl_rnd[60:32];
        c1_reg[4]   <= c1_next;
        c2_s4_reg   <= c2_s3_reg;
        c3_s4_reg   <= c3_s3_reg;
        u2p9_s4_reg <= u2p9_reg;
        up1_s4_reg  <= up1_s3_reg;
        // Stage 5
        c0_reg[5]   <= c0_next;
        h3_reg      <= 62'(t_reg[4]) * 62'(c3_s4_reg);
        tsat_reg[5] <= tsat_next;
        c2_s5_reg   <= c2_s4_reg;
        // Stage 6
        g2_reg <= 61'(h3_reg) + 61'(c2_s5_reg);
        // Stage 9
        g1_reg <= 88'(h2) + 88'(c1_reg[8]);
        // Delay lines
        for (int i = 5; i <= 9; i++)
        begin
            t_reg[i] <= t_reg[i-1];
        end
        for (int i = 5; i <= 8; i++)
        begin
            c1_reg[i] <= c1_reg[i-1];
        end
        for (int i = 6; i <= 11; i++)
        begin
            c0_reg[i]   <= c0_reg[i-1];
            tsat_reg[i] <= tsat_reg[i-1];
        end
        // Stage 12
        result_reg <= result_next;
    end

    assign done   = valid_reg[NSTG];
    assign result = result_reg;

endmodule
